[design/aes_pkg.sv]
// Package with AES-128 tables, byte helpers and shared types.
`timescale 1ns / 1ps
package aes_pkg;

  localparam int unsigned NumRounds = 10;

  typedef logic [127:0] blk_t;

  typedef struct packed {
    logic valid;
    logic op;
  } stg_ctl_t;

  localparam logic [7:0] ReduceConst = 8'h1b;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  localparam logic [7:0] RCON [11] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

  // Byte i of a block sits in bits 127-8i downto 120-8i.
  function automatic logic [7:0] get_byte(input blk_t b, input int unsigned i);
    get_byte = b[127 - 8 * i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? ReduceConst : 8'h00);
  endfunction

  function automatic blk_t sub_fwd(input blk_t s);
    blk_t o;
    for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = FWD_BOX[get_byte(s, i)];
    sub_fwd = o;
  endfunction

  function automatic blk_t sub_inv(input blk_t s);
    blk_t o;
    for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = INV_BOX[get_byte(s, i)];
    sub_inv = o;
  endfunction

  function automatic blk_t shift_fwd(input blk_t s);
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (4 * c + r) -: 8] = get_byte(s, 4 * ((c + r) % 4) + r);
      end
    end
    shift_fwd = o;
  endfunction

  function automatic blk_t shift_inv(input blk_t s);
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = get_byte(s, 4 * c + r);
      end
    end
    shift_inv = o;
  endfunction

  function automatic blk_t mix_fwd(input blk_t s);
    blk_t o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4 * c);
      a1 = get_byte(s, 4 * c + 1);
      a2 = get_byte(s, 4 * c + 2);
      a3 = get_byte(s, 4 * c + 3);
      o[127 - 8 * (4 * c) -: 8]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[127 - 8 * (4 * c + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[127 - 8 * (4 * c + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[127 - 8 * (4 * c + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_fwd = o;
  endfunction

  // Inverse mix as a preconditioning step followed by the forward mix.
  function automatic blk_t mix_inv(input blk_t s);
    blk_t p;
    logic [7:0] u, v;
    for (int c = 0; c < 4; c++) begin
      u = xtime(xtime(get_byte(s, 4 * c) ^ get_byte(s, 4 * c + 2)));
      v = xtime(xtime(get_byte(s, 4 * c + 1) ^ get_byte(s, 4 * c + 3)));
      p[127 - 8 * (4 * c) -: 8]     = get_byte(s, 4 * c) ^ u;
      p[127 - 8 * (4 * c + 1) -: 8] = get_byte(s, 4 * c + 1) ^ v;
      p[127 - 8 * (4 * c + 2) -: 8] = get_byte(s, 4 * c + 2) ^ u;
      p[127 - 8 * (4 * c + 3) -: 8] = get_byte(s, 4 * c + 3) ^ v;
    end
    mix_inv = mix_fwd(p);
  endfunction

  // Next round key from the previous one, round number rnd from 1 to 10.
  function automatic blk_t next_key(input blk_t k, input int unsigned rnd);
    blk_t o;
    logic [31:0] t;
    t = {FWD_BOX[k[23:16]] ^ RCON[rnd], FWD_BOX[k[15:8]], FWD_BOX[k[7:0]],
         FWD_BOX[k[31:24]]};
    o[127:96] = k[127:96] ^ t;
    o[95:64]  = k[95:64] ^ o[127:96];
    o[63:32]  = k[63:32] ^ o[95:64];
    o[31:0]   = k[31:0] ^ o[63:32];
    next_key = o;
  endfunction

endpackage

[design/aes128_block_cipher_top.sv]
// Top level of the pipelined AES-128 block cipher.
`timescale 1ns / 1ps
// Usage: write the key with cfg_we, index 0 for key bytes 0..7 and index 1
// for key bytes 8..15, while the pipeline is empty. The round keys are
// expanded into a chain of registers, each from the one before it, and a
// beat that enters before the last of them is in place uses stale keys.
// Input beats carry op (0 encrypt, 1 decrypt) and the 128-bit block on
// in_block_high and in_block_low; output beats carry the result block.
// The pipeline has one initial key stage and ten round stages. One beat
// enters every cycle while the pipeline advances, that is while the final
// stage is empty or out_ready is high, since every stage then takes a beat.
// When the receiver stalls, the whole pipeline holds and in_ready falls
// only while the final stage holds an untaken result, so nothing is lost.
// Reset clears the key to zero and empties the pipeline.
module aes128_block_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low
);
  import aes_pkg::*;

  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow  = 1'b1;

  logic [127:0] key_r;
  blk_t         rk_r [NumRounds + 1];
  blk_t         rk_nxt [NumRounds + 1];
  stg_ctl_t     ctl [NumRounds + 1];
  blk_t         st [NumRounds + 1];
  stg_ctl_t     ctl0_r;
  blk_t         st0_r;
  logic         adv;

  assign adv      = !ctl[NumRounds].valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    rk_nxt[0] = key_r;
    for (int i = 1; i <= NumRounds; i++) rk_nxt[i] = next_key(rk_r[i - 1], i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegKeyHigh: key_r[127:64] <= cfg_data;
        RegKeyLow:  key_r[63:0]   <= cfg_data;
        default:    key_r         <= key_r;
      endcase
    end
    for (int i = 0; i <= NumRounds; i++) rk_r[i] <= rk_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (adv) begin
      ctl0_r <= '{valid: in_valid, op: in_op};
    end
    if (adv) begin
      st0_r <= {in_block_high, in_block_low} ^ (in_op ? rk_r[NumRounds] : rk_r[0]);
    end
  end

  assign ctl[0] = ctl0_r;
  assign st[0]  = st0_r;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes_round u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .last     (g == NumRounds),
      .ctl_in   (ctl[g - 1]),
      .state_in (st[g - 1]),
      .ekey     (rk_r[g]),
      .dkey     (rk_r[NumRounds - g]),
      .ctl_out  (ctl[g]),
      .state_out(st[g])
    );
  end

  assign out_valid       = ctl[NumRounds].valid;
  assign out_result_high = st[NumRounds][127:64];
  assign out_result_low  = st[NumRounds][63:0];
endmodule

[design/aes_round.sv]
// One pipelined AES round stage serving both encryption and decryption.
`timescale 1ns / 1ps
module aes_round (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          last,
  input  aes_pkg::stg_ctl_t ctl_in,
  input  aes_pkg::blk_t state_in,
  input  aes_pkg::blk_t ekey,
  input  aes_pkg::blk_t dkey,
  output aes_pkg::stg_ctl_t ctl_out,
  output aes_pkg::blk_t state_out
);
  import aes_pkg::*;

  stg_ctl_t ctl_r;
  blk_t     state_r, state_nxt;
  blk_t     e_t, d_t;

  always_comb begin
    e_t = shift_fwd(sub_fwd(state_in));
    if (!last) e_t = mix_fwd(e_t);
    e_t = e_t ^ ekey;
    d_t = sub_inv(shift_inv(state_in)) ^ dkey;
    if (!last) d_t = mix_inv(d_t);
    state_nxt = ctl_in.op ? d_t : e_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_in;
    end
    if (adv) state_r <= state_nxt;
  end

  assign ctl_out   = ctl_r;
  assign state_out = state_r;
endmodule

[verif/aes128_block_cipher_top_tb.sv]
// Self-checking testbench for the pipelined AES-128 block cipher.
`timescale 1ns / 1ps

class aes_scoreboard;
  logic [7:0]   round_key [176];
  logic [127:0] pending_blocks [$];
  int           error_count;

  function new();
    error_count = 0;
    load_key(64'h0, 64'h0);
  endfunction

  function logic [7:0] gf_mult(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int n = 0; n < 8; n++) begin
      if (b[0]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  function void load_key(logic [63:0] key_hi, logic [63:0] key_lo);
    logic [127:0] key;
    logic [7:0]   t [4];
    logic [7:0]   r;
    key = {key_hi, key_lo};
    for (int i = 0; i < 16; i++) round_key[i] = key[127 - 8 * i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = round_key[i - 4 + j];
      if ((i % 16) == 0) begin
        r = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = r;
        for (int j = 0; j < 4; j++) t[j] = aes_pkg::FWD_BOX[t[j]];
        t[0] = t[0] ^ aes_pkg::RCON[i / 16];
      end
      for (int j = 0; j < 4; j++) round_key[i + j] = round_key[i - 16 + j] ^ t[j];
    end
  endfunction

  function logic [127:0] cipher_block(bit dec, logic [127:0] blk);
    logic [7:0]   s [16];
    logic [7:0]   o [16];
    logic [7:0]   a [4];
    logic [7:0]   m [4];
    logic [7:0]   v;
    logic [127:0] res;
    int           rnd;
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
    if (!dec) begin
      m = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int i = 0; i < 16; i++) s[i] ^= round_key[i];
      for (rnd = 1; rnd <= 10; rnd++) begin
        for (int i = 0; i < 16; i++) s[i] = aes_pkg::FWD_BOX[s[i]];
        o = s;
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) s[4 * c + r] = o[4 * ((c + r) % 4) + r];
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = s[4 * c + k];
            for (int r = 0; r < 4; r++) begin
              v = 8'h00;
              for (int k = 0; k < 4; k++) v ^= gf_mult(a[k], m[(k - r + 4) % 4]);
              s[4 * c + r] = v;
            end
          end
        end
        for (int i = 0; i < 16; i++) s[i] ^= round_key[16 * rnd + i];
      end
    end else begin
      m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      for (int i = 0; i < 16; i++) s[i] ^= round_key[160 + i];
      for (rnd = 9; rnd >= 0; rnd--) begin
        o = s;
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) s[4 * ((c + r) % 4) + r] = o[4 * c + r];
        for (int i = 0; i < 16; i++) s[i] = aes_pkg::INV_BOX[s[i]];
        for (int i = 0; i < 16; i++) s[i] ^= round_key[16 * rnd + i];
        if (rnd > 0) begin
          for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = s[4 * c + k];
            for (int r = 0; r < 4; r++) begin
              v = 8'h00;
              for (int k = 0; k < 4; k++) v ^= gf_mult(a[k], m[(k - r + 4) % 4]);
              s[4 * c + r] = v;
            end
          end
        end
      end
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
    return res;
  endfunction

  function void note_block(bit dec, logic [63:0] hi, logic [63:0] lo);
    pending_blocks = {pending_blocks, cipher_block(dec, {hi, lo})};
  endfunction

  function void check_result(logic [63:0] hi, logic [63:0] lo);
    logic [127:0] exp_blk;
    if (pending_blocks.size() == 0) begin
      $error("unexpected result beat %h %h", hi, lo);
      error_count++;
      return;
    end
    exp_blk = pending_blocks.pop_front();
    if (hi !== exp_blk[127:64]) begin
      $error("result_high expected %h actual %h", exp_blk[127:64], hi);
      error_count++;
    end
    if (lo !== exp_blk[63:0]) begin
      $error("result_low expected %h actual %h", exp_blk[63:0], lo);
      error_count++;
    end
  endfunction
endclass

module aes128_block_cipher_top_tb;
  localparam bit OP_ENCRYPT = 1'b0;
  localparam bit OP_DECRYPT = 1'b1;
  localparam bit KEY_HIGH_IDX = 1'b0;
  localparam bit KEY_LOW_IDX = 1'b1;
  localparam int PIPE_SETTLE = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = 1'b0;
  logic [63:0] in_block_high = '0;
  logic [63:0] in_block_low = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_result_high;
  logic [63:0] out_result_low;

  aes_scoreboard cipher_sb = new();
  int            burst_left = 0;
  int            stall_cycle = 0;

  aes128_block_cipher_top DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) cipher_sb.note_block(in_op, in_block_high, in_block_low);
    if (rst_n && out_valid && out_ready) cipher_sb.check_result(out_result_high, out_result_low);
  end

  always @(posedge clk) begin
    stall_cycle++;
    case ((stall_cycle / 300) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ((stall_cycle % 9) < 5);
      default: out_ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  task automatic send_block(bit dec, logic [63:0] hi, logic [63:0] lo);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= dec;
    in_block_high <= hi;
    in_block_low <= lo;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_key(logic [63:0] key_hi, logic [63:0] key_lo);
    in_valid <= 1'b0;
    @(posedge clk);
    while (cipher_sb.pending_blocks.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= KEY_HIGH_IDX;
    cfg_data <= key_hi;
    @(posedge clk);
    cfg_index <= KEY_LOW_IDX;
    cfg_data <= key_lo;
    @(posedge clk);
    cfg_we <= 1'b0;
    cipher_sb.load_key(key_hi, key_lo);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++)
      send_block(1'($urandom_range(0, 1)), rand_word(), rand_word());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (PIPE_SETTLE) @(posedge clk);

    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, '1, '1);

    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
    send_block(OP_DECRYPT, 64'h8000000000000000, 64'h0000000000000001);
    send_block(OP_ENCRYPT, '0, '1);
    send_block(OP_DECRYPT, '1, '0);

    write_key('1, '1);
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);

    run_random(250);
    write_key('0, '0);
    run_random(250);
    write_key({$urandom, $urandom}, {$urandom, $urandom});
    run_random(250);
    write_key('1, '0);
    run_random(250);
    write_key('0, '1);
    run_random(200);
    write_key({$urandom, $urandom}, {$urandom, $urandom});
    run_random(250);

    in_valid <= 1'b0;
    @(posedge clk);
    while (cipher_sb.pending_blocks.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
    if (cipher_sb.error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
